FILE: hw/rtl/flr_pkg.sv
// Shared types, codes and constants for the flash log record framer.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package flr_pkg;

	localparam int unsigned ADDR_W = 32;
	localparam int unsigned MAX_STUFFED_BYTES = 255;

	localparam logic [15:0] SYNC_WORD  = 16'hEEDD;
	localparam logic [7:0]  STUFF_BYTE = 8'hDD;
	localparam logic [7:0]  PAD_BYTE   = 8'hFF;
	localparam logic [31:0] ADDR_STEP  = 32'd2;

	// Item operation codes
	localparam logic [1:0] OP_BEGIN   = 2'd0;
	localparam logic [1:0] OP_PAYLOAD = 2'd1;
	localparam logic [1:0] OP_END     = 2'd2;

	// Result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BELOW    = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	// Configuration register indexes
	localparam logic CFG_REGION_START = 1'b0;
	localparam logic CFG_REGION_END   = 1'b1;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] start_address;
		logic [7:0]  record_type;
		logic [7:0]  payload_byte;
	} item_t;

	typedef struct packed {
		logic [31:0] write_address;
		logic [15:0] write_halfword;
		logic        write_valid;
		logic [31:0] consumed_bytes;
		logic [1:0]  status;
		logic        last_of_run;
	} result_t;

	// Address fold unit handshake
	typedef struct packed {
		logic        start;
		logic        ack;
		logic [31:0] address;
	} fold_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] address;
	} fold_rsp_t;

	typedef enum logic [1:0] {
		FOLD_IDLE,
		FOLD_DIV,
		FOLD_SUM,
		FOLD_DONE
	} fold_state_t;

endpackage

FILE: hw/rtl/flr_fold_unit.sv
// Start address fold: round up to even and fold back into the circular region.
// Uses a bit-serial restoring remainder for the modulo by the region span. Needs flr_pkg.
`timescale 1ns / 1ps

module flr_fold_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [31:0]       region_start,
	input  logic [31:0]       region_end,
	input  flr_pkg::fold_req_t req,
	output flr_pkg::fold_rsp_t rsp
);
	import flr_pkg::*;

	fold_state_t state_q, state_d;
	logic [31:0] rem_q, rem_d;
	logic [31:0] div_q, div_d;
	logic [31:0] span_q, span_d;
	logic [31:0] res_q, res_d;
	logic [4:0]  cnt_q, cnt_d;

	logic [31:0] rounded;
	logic [32:0] trial;

	assign rounded = req.address + {31'd0, req.address[0]};
	assign trial   = {rem_q, div_q[31]} - {1'b0, span_q};

	// Next state: simple folds finish at once, the modulo takes one bit a cycle
	always_comb begin
		state_d = state_q;
		rem_d   = rem_q;
		div_d   = div_q;
		span_d  = span_q;
		res_d   = res_q;
		cnt_d   = cnt_q;
		case (state_q)
			FOLD_IDLE: begin
				if (req.start) begin
					if (rounded <= region_end) begin
						res_d   = rounded;
						state_d = FOLD_DONE;
					end else if (region_end <= region_start) begin
						res_d   = rounded - region_end + region_start;
						state_d = FOLD_DONE;
					end else begin
						rem_d   = '0;
						div_d   = rounded - region_end - 32'd1;
						span_d  = region_end - region_start;
						cnt_d   = 5'd31;
						state_d = FOLD_DIV;
					end
				end
			end
			FOLD_DIV: begin
				if (!trial[32]) begin
					rem_d = trial[31:0];
				end else begin
					rem_d = {rem_q[30:0], div_q[31]};
				end
				div_d = {div_q[30:0], 1'b0};
				cnt_d = cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					state_d = FOLD_SUM;
				end
			end
			FOLD_SUM: begin
				res_d   = region_start + 32'd1 + rem_q;
				state_d = FOLD_DONE;
			end
			FOLD_DONE: begin
				if (req.ack) begin
					state_d = FOLD_IDLE;
				end
			end
			default: begin
				state_d = FOLD_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FOLD_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// Datapath holds no reset
	always_ff @(posedge clk) begin
		rem_q  <= rem_d;
		div_q  <= div_d;
		span_q <= span_d;
		res_q  <= res_d;
	end

	assign rsp.done    = (state_q == FOLD_DONE);
	assign rsp.address = res_q;

	fold_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> state_q == FOLD_IDLE)
		else $error("fold started while busy");

	fold_ack_done: assert property (@(posedge clk) disable iff (!arst_n)
		req.ack |-> state_q == FOLD_DONE)
		else $error("fold acknowledged before done");

	fold_div_to_sum: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FOLD_DIV && cnt_q == 5'd0 |=> state_q == FOLD_SUM)
		else $error("fold remainder did not finish after 32 steps");

endmodule

FILE: hw/rtl/flr_out_queue.sv
// Two-entry result queue between the framing logic and the result channel.
// Parts the two sides so the framer keeps going while a result waits. Needs flr_pkg.
`timescale 1ns / 1ps

module flr_out_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  flr_pkg::result_t push_item,
	output logic             space,
	output logic             valid,
	input  logic             ready,
	output flr_pkg::result_t item
);
	import flr_pkg::*;

	result_t    entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign space = (count_q != 2'd2);
	assign valid = (count_q != 2'd0);
	assign pop   = valid && ready;
	assign item  = entry_q[rd_ptr_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	queue_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> space)
		else $error("result pushed into a full queue");

	queue_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("result queue count out of range");

	queue_count_move: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 2'd1)
		else $error("result queue count did not follow a push");

endmodule

FILE: hw/rtl/flash_log_record_framer.sv
// Frames log records into halfword flash writes for a circular region (top level).
// Needs flr_pkg, flr_fold_unit and flr_out_queue.
//
// Usage:
//   item channel   : item_valid/item_ready, one item_t beat per begin, payload
//                    byte or end of record.
//   result channel : result_valid/result_ready, one result_t beat per flash write
//                    or status report; last_of_run marks the final beat of an item.
//   cfg channel    : cfg_valid/cfg_ready (always ready), cfg_index selects
//                    region_start or region_end, cfg_data is the value.
// Flow: an accepted item is registered and framed from the input register;
// its result then waits in the result queue for the result channel.
// Throughput: payload bytes go at one per cycle while the queue has space.
// An end item writes an odd tail byte with padding before its header. A
// begin item starts the fold unit and waits for its result, unless its start
// lies below region_start; past region_end of a proper region the fold unit
// works out the remainder by the span one bit per cycle.
// Reset clears the region to 0..65535 and closes any open record.
// When the receiver stalls, results wait in a two-entry queue; once it is full
// the framer holds any item that needs a result and item_ready drops.
`timescale 1ns / 1ps

module flash_log_record_framer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  flr_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output flr_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic             cfg_index,
	input  logic [31:0]      cfg_data
);
	import flr_pkg::*;

	function automatic logic [31:0] step_addr(input logic [31:0] a,
		input logic [31:0] rs, input logic [31:0] re);
		logic [31:0] n;
		n = a + ADDR_STEP;
		if (n > re) begin
			n = n - re + rs;
		end
		return n;
	endfunction

	// Configuration
	logic [31:0] region_start_q;
	logic [31:0] region_end_q;

	// Input register
	logic  valid_s1;
	item_t item_s1;

	// Record state
	logic        record_open_q, record_open_d;
	logic        record_failed_q, record_failed_d;
	logic [31:0] original_address_q, original_address_d;
	logic [31:0] header_address_q, header_address_d;
	logic [31:0] last_write_address_q, last_write_address_d;
	logic [7:0]  stuffed_count_q, stuffed_count_d;
	logic [7:0]  held_byte_q, held_byte_d;
	logic        held_valid_q, held_valid_d;
	logic [7:0]  type_latch_q, type_latch_d;
	logic        overflow_seen_q, overflow_seen_d;
	logic        begun_q, begun_d;

	fold_req_t fold_req;
	fold_rsp_t fold_rsp;

	logic    push;
	result_t push_item;
	logic    space;
	logic    retire;

	logic        is_stuff;
	logic [8:0]  stuffed_sum;
	logic [31:0] next_write;
	logic [31:0] fold_header;

	assign cfg_ready  = 1'b1;
	assign item_ready = !valid_s1 || retire;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_start_q <= 32'd0;
			region_end_q   <= 32'd65535;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_REGION_START: region_start_q <= cfg_data;
				CFG_REGION_END:   region_end_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Hold the accepted beat until it retires
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	assign is_stuff    = (item_s1.payload_byte == STUFF_BYTE);
	assign stuffed_sum = {1'b0, stuffed_count_q} + (is_stuff ? 9'd2 : 9'd1);
	assign next_write  = step_addr(last_write_address_q, region_start_q, region_end_q);
	assign fold_header = step_addr(fold_rsp.address, region_start_q, region_end_q);

	// Frame the held item against the record state
	always_comb begin
		push                 = 1'b0;
		push_item            = '0;
		retire               = 1'b0;
		fold_req             = '0;
		fold_req.address     = item_s1.start_address;
		record_open_d        = record_open_q;
		record_failed_d      = record_failed_q;
		original_address_d   = original_address_q;
		header_address_d     = header_address_q;
		last_write_address_d = last_write_address_q;
		stuffed_count_d      = stuffed_count_q;
		held_byte_d          = held_byte_q;
		held_valid_d         = held_valid_q;
		type_latch_d         = type_latch_q;
		overflow_seen_d      = overflow_seen_q;
		begun_d              = begun_q;

		if (valid_s1) begin
			case (item_s1.op)
				OP_BEGIN: begin
					if (item_s1.start_address < region_start_q) begin
						if (space) begin
							push                = 1'b1;
							push_item.status    = ST_BELOW;
							push_item.last_of_run = 1'b1;
							retire              = 1'b1;
							record_failed_d     = 1'b1;
							header_address_d    = '0;
							last_write_address_d = '0;
						end
					end else if (!begun_q) begin
						fold_req.start = 1'b1;
						begun_d        = 1'b1;
					end else if (fold_rsp.done && space) begin
						fold_req.ack             = 1'b1;
						push                     = 1'b1;
						push_item.write_address  = fold_rsp.address;
						push_item.write_halfword = SYNC_WORD;
						push_item.write_valid    = 1'b1;
						push_item.last_of_run    = 1'b1;
						retire                   = 1'b1;
						begun_d                  = 1'b0;
						record_failed_d          = 1'b0;
						header_address_d         = fold_header;
						last_write_address_d     = fold_header;
					end
					if (retire) begin
						record_open_d      = 1'b1;
						original_address_d = item_s1.start_address;
						type_latch_d       = item_s1.record_type;
						stuffed_count_d    = '0;
						held_byte_d        = '0;
						held_valid_d       = 1'b0;
						overflow_seen_d    = 1'b0;
					end
				end
				OP_PAYLOAD: begin
					if (!record_open_q || record_failed_q) begin
						retire = 1'b1;
					end else if (stuffed_sum > 9'(MAX_STUFFED_BYTES)) begin
						// Drop the whole byte
						retire          = 1'b1;
						overflow_seen_d = 1'b1;
					end else if (!is_stuff && !held_valid_q) begin
						retire          = 1'b1;
						stuffed_count_d = stuffed_sum[7:0];
						held_byte_d     = item_s1.payload_byte;
						held_valid_d    = 1'b1;
					end else if (space) begin
						retire                   = 1'b1;
						push                     = 1'b1;
						stuffed_count_d          = stuffed_sum[7:0];
						last_write_address_d     = next_write;
						push_item.write_address  = next_write;
						push_item.write_valid    = 1'b1;
						push_item.last_of_run    = 1'b1;
						if (!is_stuff) begin
							push_item.write_halfword = {item_s1.payload_byte, held_byte_q};
							held_valid_d             = 1'b0;
						end else if (held_valid_q) begin
							// Held byte pairs with the first copy, the second is held
							push_item.write_halfword = {STUFF_BYTE, held_byte_q};
							held_byte_d              = STUFF_BYTE;
						end else begin
							push_item.write_halfword = {STUFF_BYTE, STUFF_BYTE};
						end
					end
				end
				OP_END: begin
					if (!record_open_q) begin
						retire = 1'b1;
					end else if (space) begin
						push = 1'b1;
						if (record_failed_q) begin
							push_item.status      = ST_BELOW;
							push_item.last_of_run = 1'b1;
							retire                = 1'b1;
							record_open_d         = 1'b0;
							record_failed_d       = 1'b0;
						end else if (held_valid_q) begin
							// Pad the odd tail; the header beat follows once the queue has space
							push_item.write_address  = next_write;
							push_item.write_halfword = {PAD_BYTE, held_byte_q};
							push_item.write_valid    = 1'b1;
							last_write_address_d     = next_write;
							held_valid_d             = 1'b0;
						end else begin
							push_item.write_address  = header_address_q;
							push_item.write_halfword = {stuffed_count_q, type_latch_q};
							push_item.write_valid    = 1'b1;
							push_item.consumed_bytes = last_write_address_q
								- original_address_q + ADDR_STEP;
							push_item.status         = overflow_seen_q ? ST_OVERFLOW : ST_OK;
							push_item.last_of_run    = 1'b1;
							retire                   = 1'b1;
							record_open_d            = 1'b0;
							held_byte_d              = '0;
							stuffed_count_d          = '0;
							overflow_seen_d          = 1'b0;
						end
					end
				end
				default: begin
					retire = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			record_open_q        <= 1'b0;
			record_failed_q      <= 1'b0;
			original_address_q   <= '0;
			header_address_q     <= '0;
			last_write_address_q <= '0;
			stuffed_count_q      <= '0;
			held_byte_q          <= '0;
			held_valid_q         <= 1'b0;
			type_latch_q         <= '0;
			overflow_seen_q      <= 1'b0;
			begun_q              <= 1'b0;
		end else begin
			record_open_q        <= record_open_d;
			record_failed_q      <= record_failed_d;
			original_address_q   <= original_address_d;
			header_address_q     <= header_address_d;
			last_write_address_q <= last_write_address_d;
			stuffed_count_q      <= stuffed_count_d;
			held_byte_q          <= held_byte_d;
			held_valid_q         <= held_valid_d;
			type_latch_q         <= type_latch_d;
			overflow_seen_q      <= overflow_seen_d;
			begun_q              <= begun_d;
		end
	end

	flr_fold_unit u_fold (
		.clk          (clk),
		.arst_n       (arst_n),
		.region_start (region_start_q),
		.region_end   (region_end_q),
		.req          (fold_req),
		.rsp          (fold_rsp)
	);

	flr_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.space     (space),
		.valid     (result_valid),
		.ready     (result_ready),
		.item      (result)
	);

	failed_implies_open: assert property (@(posedge clk) disable iff (!arst_n)
		record_failed_q |-> record_open_q)
		else $error("failed record is not open");

	failed_holds_nothing: assert property (@(posedge clk) disable iff (!arst_n)
		record_failed_q |-> !held_valid_q)
		else $error("failed record holds a payload byte");

	count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, stuffed_count_q} <= 9'(MAX_STUFFED_BYTES))
		else $error("stuffed length beyond limit");

	nowrite_is_error: assert property (@(posedge clk) disable iff (!arst_n)
		push && !push_item.write_valid |-> push_item.status == ST_BELOW)
		else $error("result without write that is not a start error");

	pad_then_header: assert property (@(posedge clk) disable iff (!arst_n)
		push && !push_item.last_of_run |=> valid_s1 && item_s1.op == OP_END)
		else $error("padding write not followed by its header");

endmodule

FILE: tb/sv/flr_record_checker.sv
// Scoreboard for the flash log record framer: watches the cfg, item and result channels.
// Predicts the flash writes and status beats of each item and compares them in order.
// Depends on flr_pkg for the beat types, codes and framing constants.
`timescale 1ns / 1ps

module flr_record_checker
	import flr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic              item_ready,
	input  item_t             item,
	input  logic              result_valid,
	input  logic              result_ready,
	input  result_t           result,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [31:0]       cfg_data,
	output int unsigned       fail_count,
	output int unsigned       awaited
);

	// Region registers as the framer should see them
	logic [31:0] region_lo;
	logic [31:0] region_hi;

	// Open record bookkeeping
	logic        rec_open;
	logic        rec_failed;
	logic [31:0] rec_origin;
	logic [31:0] hdr_addr;
	logic [31:0] last_addr;
	int unsigned stuffed;
	logic [7:0]  held_byte;
	logic        held_ok;
	logic [7:0]  rec_type;
	logic        overflowed;

	// Beats still owed by the framer, oldest first
	result_t pending_beats[$];

	// Fold an address that lies past the region end back into the region
	function automatic logic [31:0] fold_address(input logic [31:0] a);
		if (a <= region_hi)
			return a;
		if (region_hi <= region_lo)
			return a - region_hi + region_lo;
		return region_lo + 32'd1 + ((a - region_hi - 32'd1) % (region_hi - region_lo));
	endfunction

	// Advance one halfword, wrapping past the region end
	function automatic logic [31:0] next_address(input logic [31:0] a);
		logic [31:0] b;
		b = a + ADDR_STEP;
		if (b > region_hi)
			b = b - region_hi + region_lo;
		return b;
	endfunction

	task automatic owe_beat(input logic [31:0] addr, input logic [15:0] hw, input logic wr,
			input logic [31:0] used, input logic [1:0] st, input logic last);
		result_t b;
		b.write_address  = addr;
		b.write_halfword = hw;
		b.write_valid    = wr;
		b.consumed_bytes = used;
		b.status         = st;
		b.last_of_run    = last;
		pending_beats.push_back(b);
	endtask

	task automatic owe_data(input logic [7:0] lo, input logic [7:0] hi);
		last_addr = next_address(last_addr);
		owe_beat(last_addr, {hi, lo}, 1'b1, 32'd0, ST_OK, 1'b1);
	endtask

	// Work out the beats one accepted item causes and update the record state
	task automatic frame_item(input item_t it);
		logic [31:0] a;
		int unsigned need;
		case (it.op)
			OP_BEGIN: begin
				rec_open   = 1'b1;
				rec_origin = it.start_address;
				rec_type   = it.record_type;
				stuffed    = 0;
				held_byte  = 8'h00;
				held_ok    = 1'b0;
				overflowed = 1'b0;
				hdr_addr   = 32'd0;
				last_addr  = 32'd0;
				if (it.start_address < region_lo) begin
					rec_failed = 1'b1;
					owe_beat(32'd0, 16'h0000, 1'b0, 32'd0, ST_BELOW, 1'b1);
				end else begin
					rec_failed = 1'b0;
					a = fold_address(it.start_address + {31'd0, it.start_address[0]});
					hdr_addr  = next_address(a);
					last_addr = hdr_addr;
					owe_beat(a, SYNC_WORD, 1'b1, 32'd0, ST_OK, 1'b1);
				end
			end
			OP_PAYLOAD: begin
				if (rec_open && !rec_failed) begin
					need = (it.payload_byte == STUFF_BYTE) ? 2 : 1;
					if (stuffed + need > MAX_STUFFED_BYTES) begin
						// drop the whole byte, report it at the end
						overflowed = 1'b1;
					end else begin
						stuffed = stuffed + need;
						if (need == 1) begin
							if (held_ok) begin
								held_ok = 1'b0;
								owe_data(held_byte, it.payload_byte);
							end else begin
								held_byte = it.payload_byte;
								held_ok   = 1'b1;
							end
						end else if (held_ok) begin
							// first copy pairs with the held byte, second copy is held
							owe_data(held_byte, STUFF_BYTE);
							held_byte = STUFF_BYTE;
						end else begin
							owe_data(STUFF_BYTE, STUFF_BYTE);
						end
					end
				end
			end
			OP_END: begin
				if (rec_open) begin
					rec_open = 1'b0;
					if (rec_failed) begin
						rec_failed = 1'b0;
						owe_beat(32'd0, 16'h0000, 1'b0, 32'd0, ST_BELOW, 1'b1);
					end else begin
						// pad an odd tail, then the header goes last
						if (held_ok) begin
							last_addr = next_address(last_addr);
							owe_beat(last_addr, {PAD_BYTE, held_byte}, 1'b1, 32'd0, ST_OK, 1'b0);
							held_ok = 1'b0;
						end
						owe_beat(hdr_addr, {8'(stuffed), rec_type}, 1'b1,
							last_addr - rec_origin + 32'd2,
							overflowed ? ST_OVERFLOW : ST_OK, 1'b1);
						held_byte  = 8'h00;
						stuffed    = 0;
						overflowed = 1'b0;
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic compare_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
		end
	endtask

	// Sample all three channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			region_lo  = 32'd0;
			region_hi  = 32'd65535;
			rec_open   = 1'b0;
			rec_failed = 1'b0;
			rec_origin = 32'd0;
			hdr_addr   = 32'd0;
			last_addr  = 32'd0;
			stuffed    = 0;
			held_byte  = 8'h00;
			held_ok    = 1'b0;
			rec_type   = 8'h00;
			overflowed = 1'b0;
			pending_beats.delete();
			fail_count = 0;
			awaited    = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_REGION_START)
					region_lo = cfg_data;
				else
					region_hi = cfg_data;
			end
			if (result_valid && result_ready) begin
				if (pending_beats.size() == 0) begin
					fail_count++;
					$display("%0t: result beat with nothing expected, got %h", $time, result);
				end else begin
					want = pending_beats.pop_front();
					compare_field("write_address", want.write_address, result.write_address);
					compare_field("write_halfword", 32'(want.write_halfword),
						32'(result.write_halfword));
					compare_field("write_valid", 32'(want.write_valid),
						32'(result.write_valid));
					compare_field("consumed_bytes", want.consumed_bytes, result.consumed_bytes);
					compare_field("status", 32'(want.status), 32'(result.status));
					compare_field("last_of_run", 32'(want.last_of_run),
						32'(result.last_of_run));
				end
			end
			if (item_valid && item_ready)
				frame_item(item);
			awaited = pending_beats.size();
		end
	end

endmodule

FILE: tb/sv/testbench.sv
// Top of the flash log record framer regression: clock, reset, stimulus and verdict.
// Needs flr_pkg, the framer RTL and flr_record_checker, which predicts and compares.
`timescale 1ns / 1ps

module testbench;
	import flr_pkg::*;

	// Item code the framer ignores
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int unsigned LONG_HOLD = 400;
	localparam int unsigned DRAIN_CYCLES = 60;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        item_valid;
	logic        item_ready;
	item_t       item;
	logic        result_valid;
	logic        result_ready;
	result_t     result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [31:0] cfg_data;

	int unsigned fail_count;
	int unsigned awaited;

	// Stimulus knobs shared by the sender and receiver processes
	bit          gaps_on;
	bit          long_hold_req;
	int unsigned sent;
	logic [31:0] reg_lo;
	logic [31:0] reg_hi;

	always #10 clk = ~clk;

	flash_log_record_framer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	flr_record_checker record_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.awaited      (awaited)
	);

	// Random filler byte for fields the item does not use
	function automatic logic [7:0] rand_byte();
		return 8'($urandom());
	endfunction

	// Offer one item beat, with an occasional gap in front, and hold until taken
	task automatic offer_item(input logic [1:0] op, input logic [31:0] sa,
			input logic [7:0] rt, input logic [7:0] pb);
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 9) == 0) begin
			item_valid = 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		item = '{op: op, start_address: sa, record_type: rt, payload_byte: pb};
		item_valid = 1'b1;
		do @(posedge clk); while (!item_ready);
		if (op != OP_UNUSED)
			sent++;
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] val);
		@(negedge clk);
		cfg_index = idx;
		cfg_data  = val;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Drop valid, wait for every owed beat, then let a slow begin finish
	task automatic settle();
		@(negedge clk);
		item_valid = 1'b0;
		while (awaited != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_region(input logic [31:0] lo, input logic [31:0] hi);
		settle();
		write_reg(CFG_REGION_START, lo);
		write_reg(CFG_REGION_END, hi);
		reg_lo = lo;
		reg_hi = hi;
	endtask

	// Start addresses: mostly inside the region, some below, past the end or extreme
	function automatic logic [31:0] pick_start();
		int unsigned r;
		logic [31:0] span;
		r = $urandom_range(0, 99);
		span = reg_hi - reg_lo;
		if (r < 12)
			return $urandom();
		if (r < 24 && reg_lo != 32'd0)
			return $urandom_range(0, reg_lo - 32'd1);
		if (r < 40)
			return reg_hi + $urandom_range(1, 600);
		if (r < 48) begin
			case ($urandom_range(0, 3))
				0:       return 32'hFFFF_FFFF;
				1:       return reg_lo;
				2:       return reg_hi;
				default: return reg_hi - 32'd1;
			endcase
		end
		if (reg_hi < reg_lo)
			return reg_lo + $urandom_range(0, 64);
		if (span == 32'hFFFF_FFFF)
			return $urandom();
		return reg_lo + ($urandom() % (span + 32'd1));
	endfunction

	// Payload bytes lean on the stuffed value so records overflow now and then
	function automatic logic [7:0] pick_byte();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 25)
			return STUFF_BYTE;
		if (r < 30)
			return PAD_BYTE;
		if (r < 35)
			return 8'h00;
		return rand_byte();
	endfunction

	// Random records for the current region until the quota of items is offered
	task automatic run_records(input int unsigned quota);
		int unsigned target;
		int unsigned pick;
		int unsigned len;
		target = sent + quota;
		while (sent < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				// well-formed record, mostly short, a few long enough to overflow
				len = $urandom_range(0, 99);
				if (len < 70)
					len = $urandom_range(0, 20);
				else if (len < 90)
					len = $urandom_range(21, 140);
				else
					len = $urandom_range(200, 300);
				offer_item(OP_BEGIN, pick_start(), rand_byte(), rand_byte());
				repeat (len) offer_item(OP_PAYLOAD, $urandom(), rand_byte(), pick_byte());
				offer_item(OP_END, $urandom(), rand_byte(), rand_byte());
			end else if (pick < 88) begin
				// record left open, the next begin abandons it
				offer_item(OP_BEGIN, pick_start(), rand_byte(), rand_byte());
				repeat ($urandom_range(0, 8))
					offer_item(OP_PAYLOAD, $urandom(), rand_byte(), pick_byte());
			end else begin
				// noise: any code, any fields
				repeat ($urandom_range(1, 6))
					offer_item(2'($urandom_range(0, 3)), pick_start(), rand_byte(),
						pick_byte());
			end
		end
	endtask

	// Receiver: random stalls, one long hold-off on request
	initial begin
		int unsigned hold_cycles;
		result_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				result_ready = 1'b0;
				hold_cycles = 0;
				while (hold_cycles < LONG_HOLD) begin
					@(negedge clk);
					hold_cycles++;
				end
				long_hold_req = 1'b0;
			end else if (gaps_on && $urandom_range(0, 7) == 0) begin
				result_ready = 1'b0;
				repeat ($urandom_range(1, 18)) @(negedge clk);
			end
			result_ready = 1'b1;
		end
	end

	// Main sequence
	initial begin
		logic [31:0] lo_list [9];
		logic [31:0] hi_list [9];
		logic [31:0] rand_lo;
		arst_n        = 1'b0;
		item_valid    = 1'b0;
		item          = '0;
		cfg_valid     = 1'b0;
		cfg_index     = CFG_REGION_START;
		cfg_data      = 32'd0;
		gaps_on       = 1'b0;
		long_hold_req = 1'b0;
		sent          = 0;
		reg_lo        = 32'd0;
		reg_hi        = 32'd65535;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// Directed: reset region 0..65535
		offer_item(OP_BEGIN, 32'hFFFF_FFFF, 8'hFF, rand_byte());   // round up wraps to zero
		offer_item(OP_PAYLOAD, $urandom(), rand_byte(), STUFF_BYTE); // doubled on its own
		offer_item(OP_PAYLOAD, $urandom(), rand_byte(), 8'h00);      // held
		offer_item(OP_PAYLOAD, $urandom(), rand_byte(), STUFF_BYTE); // pairs, second copy held
		offer_item(OP_PAYLOAD, $urandom(), rand_byte(), 8'hFF);
		offer_item(OP_PAYLOAD, $urandom(), rand_byte(), 8'h5A);      // odd tail
		offer_item(OP_END, $urandom(), rand_byte(), rand_byte());    // pad, then header
		offer_item(OP_PAYLOAD, $urandom(), rand_byte(), 8'h33);      // no record open
		offer_item(OP_END, $urandom(), rand_byte(), rand_byte());
		offer_item(OP_UNUSED, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
		offer_item(OP_BEGIN, 32'h0001_FFFF, 8'h00, rand_byte());     // past region end
		offer_item(OP_PAYLOAD, $urandom(), rand_byte(), 8'h01);
		offer_item(OP_BEGIN, 32'h0000_FFFF, 8'hA5, rand_byte());     // abandon open record
		offer_item(OP_END, $urandom(), rand_byte(), rand_byte());    // empty record
		offer_item(OP_BEGIN, 32'h0000_FFFE, 8'h3C, rand_byte());     // header wraps
		offer_item(OP_PAYLOAD, $urandom(), rand_byte(), STUFF_BYTE);
		offer_item(OP_PAYLOAD, $urandom(), rand_byte(), STUFF_BYTE);
		offer_item(OP_END, $urandom(), rand_byte(), rand_byte());

		// Directed: start below the region
		set_region(32'h0000_0100, 32'h0000_01FF);
		offer_item(OP_BEGIN, 32'h0000_00FF, 8'h77, rand_byte());
		offer_item(OP_PAYLOAD, $urandom(), rand_byte(), 8'h11);      // swallowed
		offer_item(OP_END, $urandom(), rand_byte(), rand_byte());
		offer_item(OP_BEGIN, 32'h0000_0000, 8'h80, rand_byte());
		offer_item(OP_BEGIN, 32'h0000_0100, 8'h01, rand_byte());
		offer_item(OP_END, $urandom(), rand_byte(), rand_byte());

		// Random phases over several regions, extremes and degenerate ones
		lo_list = '{32'h0000_1000, 32'h0000_0000, 32'hFFFF_FF00, 32'h0000_8000,
			32'hFFFF_FFFF, 32'h2000_0001, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000};
		hi_list = '{32'h0000_10FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_8000,
			32'h0000_0000, 32'h2000_0040, 32'h0000_4000, 32'h0000_0000, 32'h0000_0000};
		rand_lo = $urandom();
		lo_list[8] = rand_lo;
		hi_list[8] = rand_lo + $urandom_range(2, 4096);
		for (int i = 0; i < 9; i++) begin
			set_region(lo_list[i], hi_list[i]);
			gaps_on = (i % 3 != 2);
			if (i == 1)
				long_hold_req = 1'b1;
			run_records(145);
		end

		// Last part at full rate on both sides
		set_region(32'h0000_0400, 32'h0000_07FF);
		gaps_on = 1'b0;
		run_records(200);

		settle();
		if (fail_count == 0 && awaited == 0)
			$display("flash_log_record_framer regression: pass");
		else
			$display("flash_log_record_framer regression: fail");
		$finish;
	end

	// Watchdog
	initial begin
		#100_000_000;
		$display("flash_log_record_framer regression: fail");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/flr_pkg.sv
hw/rtl/flr_fold_unit.sv
hw/rtl/flr_out_queue.sv
hw/rtl/flash_log_record_framer.sv
tb/sv/flr_record_checker.sv
tb/sv/testbench.sv
